FILE: rtl/core/lwoc_pkg.sv
// ----------------------------------------------------------------------------
// LRU write-back object cache package
// Shared constants, result kind codes and the controller/datapath interface
// structs.
// ----------------------------------------------------------------------------
package lwoc_pkg;

    // Default sizes for the top-level parameters.
    localparam int DEF_ENTRIES = 32;
    localparam int DEF_ID_BITS = 16;

    // Fixed widths of the result fields.
    localparam int OBJ_W  = 16;
    localparam int SLOT_W = 5;
    localparam int KIND_W = 2;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_WB   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FILL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;    // take the input beat
        logic decide;     // latch lookup outcome and target slot
        logic wb_read;    // read the tag of the walked slot and clean it
        logic walk_step;  // move the recency walk one rank on
        logic front;      // move the target slot to the front
        logic alloc;      // take a fresh slot
        logic set_tag;    // write the object into the target slot
        logic set_dirty;  // mark the target slot dirty on a write access
        logic emit_wb;    // load a write-back beat
        logic emit_fill;  // load a fill beat
        logic emit_done;  // load the done beat
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic func;       // held item is a flush
        logic hit;        // object found in a used slot
        logic full;       // every slot is used
        logic used_zero;  // no slot is used
        logic walk_dirty; // slot at the walked rank is dirty
        logic walk_end;   // walk is at its last rank
        logic out_free;   // output register can take a beat
    } t_stat;

endpackage

FILE: rtl/core/lru_writeback_object_cache.sv
// ----------------------------------------------------------------------------
// LRU write-back object cache
// Fully associative object directory with recency order and dirty write-back.
// ----------------------------------------------------------------------------
// A hit passes from its input beat through capture and a parallel tag match
// to its done beat. The input is taken again in the cycle after the done
// beat is loaded. A miss with a free slot adds a fill beat, and a miss with
// a clean tail adds a replace step and a fill beat. A dirty eviction walks
// the recency order from the tail one rank per cycle, held while a
// write-back beat waits for the output register, and spends an extra step on
// each dirty slot for the tag RAM read before replace, fill and its done beat.
// A flush walks the used slots the same way from the front before its done
// beat. Downstream stall holds the write-back, fill and done beats.
module lru_writeback_object_cache #(
    parameter int ENTRIES = lwoc_pkg::DEF_ENTRIES,
    parameter int ID_BITS = lwoc_pkg::DEF_ID_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_func,
    input  logic [lwoc_pkg::OBJ_W-1:0]  i_object_id,
    input  logic                        i_write,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [lwoc_pkg::KIND_W-1:0] o_kind,
    output logic [lwoc_pkg::SLOT_W-1:0] o_slot,
    output logic [lwoc_pkg::OBJ_W-1:0]  o_entry_object,
    output logic                        o_hit,
    output logic                        o_last
);

    lwoc_pkg::t_cmd  cmd;
    lwoc_pkg::t_stat stat;

    // Sequencer.
    lwoc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Directory and result path.
    lwoc_dpath #(
        .ENTRIES (ENTRIES),
        .ID_BITS (ID_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_func         (i_func),
        .i_object_id    (i_object_id),
        .i_write        (i_write),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_kind         (o_kind),
        .o_slot         (o_slot),
        .o_entry_object (o_entry_object),
        .o_hit          (o_hit),
        .o_last         (o_last),
        .i_cmd          (cmd),
        .o_stat         (stat)
    );

endmodule

FILE: rtl/core/lwoc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data that holds
// until the next read.
// ----------------------------------------------------------------------------
module lwoc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/lwoc_ctrl.sv
// ----------------------------------------------------------------------------
// LRU write-back object cache controller
// Sequences lookup, dirty walks, replacement and the result beats of one item.
// ----------------------------------------------------------------------------
module lwoc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  lwoc_pkg::t_stat i_stat,
    output lwoc_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_DECIDE  = 3'd1;
    localparam logic [2:0] ST_WALK    = 3'd2;
    localparam logic [2:0] ST_WB_RD   = 3'd3;
    localparam logic [2:0] ST_REPLACE = 3'd4;
    localparam logic [2:0] ST_FILL    = 3'd5;
    localparam logic [2:0] ST_DONE    = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_stall = (r_state != ST_IDLE);

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                if (i_stat.func) begin
                    n_state = i_stat.used_zero ? ST_DONE : ST_WALK;
                end else if (i_stat.hit) begin
                    o_cmd.front     = 1'b1;
                    o_cmd.set_dirty = 1'b1;
                    n_state         = ST_DONE;
                end else if (!i_stat.full) begin
                    o_cmd.alloc   = 1'b1;
                    o_cmd.front   = 1'b1;
                    o_cmd.set_tag = 1'b1;
                    n_state       = ST_FILL;
                end else begin
                    n_state = i_stat.walk_dirty ? ST_WALK : ST_REPLACE;
                end
            end
            ST_WALK: begin
                if (i_stat.walk_dirty) begin
                    o_cmd.wb_read = 1'b1;
                    n_state       = ST_WB_RD;
                end else begin
                    o_cmd.walk_step = 1'b1;
                    if (i_stat.walk_end) begin
                        n_state = i_stat.func ? ST_DONE : ST_REPLACE;
                    end
                end
            end
            ST_WB_RD: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_wb   = 1'b1;
                    o_cmd.walk_step = 1'b1;
                    if (i_stat.walk_end) begin
                        n_state = i_stat.func ? ST_DONE : ST_REPLACE;
                    end else begin
                        n_state = ST_WALK;
                    end
                end
            end
            ST_REPLACE: begin
                o_cmd.front   = 1'b1;
                o_cmd.set_tag = 1'b1;
                n_state       = ST_FILL;
            end
            ST_FILL: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_fill = 1'b1;
                    n_state         = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_done = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/core/lwoc_dpath.sv
// ----------------------------------------------------------------------------
// LRU write-back object cache datapath
// Tag match cells, recency ranks, dirty marks, tag RAM and output register.
// ----------------------------------------------------------------------------
module lwoc_dpath #(
    parameter int ENTRIES = lwoc_pkg::DEF_ENTRIES,
    parameter int ID_BITS = lwoc_pkg::DEF_ID_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_func,
    input  logic [lwoc_pkg::OBJ_W-1:0]  i_object_id,
    input  logic                        i_write,
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic [lwoc_pkg::KIND_W-1:0] o_kind,
    output logic [lwoc_pkg::SLOT_W-1:0] o_slot,
    output logic [lwoc_pkg::OBJ_W-1:0]  o_entry_object,
    output logic                        o_hit,
    output logic                        o_last,
    input  lwoc_pkg::t_cmd              i_cmd,
    output lwoc_pkg::t_stat             o_stat
);

    localparam int SB = $clog2(ENTRIES);
    localparam int UB = $clog2(ENTRIES + 1);
    localparam int OW = lwoc_pkg::OBJ_W;
    localparam int WW = (SB > lwoc_pkg::SLOT_W) ? SB : lwoc_pkg::SLOT_W;

    // Directory state.
    logic [ID_BITS-1:0] r_tag   [ENTRIES];
    logic [SB-1:0]      r_rank  [ENTRIES];
    logic [ENTRIES-1:0] r_dirty;
    logic [UB-1:0]      r_used;

    // Held item and walk state.
    logic               r_func;
    logic [ID_BITS-1:0] r_obj;
    logic               r_wr;
    logic [SB-1:0]      r_slot;
    logic               r_hit;
    logic [SB-1:0]      r_walk;
    logic [SB-1:0]      r_wb_slot;

    // Output register.
    logic                        r_o_valid;
    logic [lwoc_pkg::KIND_W-1:0] r_o_kind;
    logic [lwoc_pkg::SLOT_W-1:0] r_o_slot;
    logic [OW-1:0]               r_o_obj;
    logic                        r_o_hit;
    logic                        r_o_last;

    logic [ENTRIES-1:0] in_use;
    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] walk_vec;
    logic [SB-1:0]      hit_slot;
    logic [SB-1:0]      walk_slot;
    logic [SB-1:0]      sel_slot;
    logic [SB-1:0]      tgt_slot;
    logic [SB-1:0]      tgt_rank;
    logic               full;
    logic               out_free;
    logic [ID_BITS-1:0] in_obj;
    logic [ID_BITS+OW-1:0] in_ext;
    logic [ID_BITS+OW-1:0] obj_ext;
    logic [OW-1:0]      obj_out;
    logic [OW-1:0]      ram_out;
    logic [ID_BITS-1:0] ram_rdata;
    logic [WW-1:0]      tgt_wide;
    logic [WW-1:0]      wb_wide;

    // Object numbers are kept at ID_BITS and shown at the low result bits.
    assign in_ext  = {{ID_BITS{1'b0}}, i_object_id};
    assign in_obj  = in_ext[ID_BITS-1:0];
    assign obj_ext = {{OW{1'b0}}, r_obj};
    assign obj_out = obj_ext[OW-1:0];

    // Parallel tag match and rank search over the used slots.
    always_comb begin
        hit_slot  = '0;
        walk_slot = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            in_use[i]    = (UB'(i) < r_used);
            match_vec[i] = in_use[i] && (r_tag[i] == r_obj);
            walk_vec[i]  = in_use[i] && (r_rank[i] == r_walk);
            if (match_vec[i]) begin
                hit_slot = SB'(i);
            end
            if (walk_vec[i]) begin
                walk_slot = SB'(i);
            end
        end
    end

    assign full     = (r_used == UB'(ENTRIES));
    assign out_free = !r_o_valid || !i_stall;
    assign sel_slot = (|match_vec) ? hit_slot : (full ? walk_slot : r_used[SB-1:0]);
    assign tgt_slot = i_cmd.decide ? sel_slot : r_slot;
    assign tgt_rank = r_rank[tgt_slot];

    // Status toward the controller.
    always_comb begin
        o_stat            = '0;
        o_stat.func       = r_func;
        o_stat.hit        = |match_vec;
        o_stat.full       = full;
        o_stat.used_zero  = (r_used == '0);
        o_stat.walk_dirty = |(walk_vec & r_dirty);
        o_stat.walk_end   = r_func ? (r_walk == SB'(r_used - UB'(1))) : (r_walk == '0);
        o_stat.out_free   = out_free;
    end

    // Held item, walk counter and target slot.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_obj  <= in_obj;
            r_wr   <= i_write;
            r_walk <= i_func ? '0 : SB'(r_used - UB'(1));
        end
        if (i_cmd.decide) begin
            r_slot <= sel_slot;
            r_hit  <= !r_func && (|match_vec);
        end
        if (i_cmd.walk_step) begin
            r_walk <= r_func ? (r_walk + SB'(1)) : (r_walk - SB'(1));
        end
        if (i_cmd.wb_read) begin
            r_wb_slot <= walk_slot;
        end
    end

    // Tag cells and recency ranks.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (i_cmd.front) begin
                if (SB'(i) == tgt_slot) begin
                    r_rank[i] <= '0;
                end else if (in_use[i] && (i_cmd.alloc || (r_rank[i] < tgt_rank))) begin
                    r_rank[i] <= r_rank[i] + SB'(1);
                end
            end
            if (i_cmd.set_tag && (SB'(i) == tgt_slot)) begin
                r_tag[i] <= r_obj;
            end
        end
    end

    // Dirty marks and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dirty <= '0;
            r_used  <= '0;
        end else begin
            if (i_cmd.wb_read) begin
                r_dirty[walk_slot] <= 1'b0;
            end
            if (i_cmd.set_tag) begin
                r_dirty[tgt_slot] <= r_wr;
            end
            if (i_cmd.set_dirty && r_wr) begin
                r_dirty[tgt_slot] <= 1'b1;
            end
            if (i_cmd.alloc) begin
                r_used <= r_used + UB'(1);
            end
        end
    end

    // Tag copy for write-back reads.
    lwoc_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (ENTRIES)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.set_tag),
        .i_waddr (tgt_slot),
        .i_wdata (r_obj),
        .i_re    (i_cmd.wb_read),
        .i_raddr (walk_slot),
        .o_rdata (ram_rdata)
    );

    // Slot and object fields reduced to the result widths.
    logic [ID_BITS+OW-1:0] ram_ext;
    assign ram_ext  = {{OW{1'b0}}, ram_rdata};
    assign ram_out  = ram_ext[OW-1:0];
    assign tgt_wide = WW'(r_slot);
    assign wb_wide  = WW'(r_wb_slot);

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit_wb || i_cmd.emit_fill || i_cmd.emit_done) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_wb) begin
            r_o_kind <= lwoc_pkg::KIND_WB;
            r_o_slot <= wb_wide[lwoc_pkg::SLOT_W-1:0];
            r_o_obj  <= ram_out;
            r_o_hit  <= 1'b0;
            r_o_last <= 1'b0;
        end else if (i_cmd.emit_fill) begin
            r_o_kind <= lwoc_pkg::KIND_FILL;
            r_o_slot <= tgt_wide[lwoc_pkg::SLOT_W-1:0];
            r_o_obj  <= obj_out;
            r_o_hit  <= 1'b0;
            r_o_last <= 1'b0;
        end else if (i_cmd.emit_done) begin
            r_o_kind <= lwoc_pkg::KIND_DONE;
            r_o_slot <= r_func ? '0 : tgt_wide[lwoc_pkg::SLOT_W-1:0];
            r_o_obj  <= r_func ? '0 : obj_out;
            r_o_hit  <= r_hit;
            r_o_last <= 1'b1;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_kind         = r_o_kind;
    assign o_slot         = r_o_slot;
    assign o_entry_object = r_o_obj;
    assign o_hit          = r_o_hit;
    assign o_last         = r_o_last;

endmodule

FILE: test/lru_writeback_object_cache_tb.sv
// ----------------------------------------------------------------------------
// LRU write-back object cache testbench
// Drives access and flush beats through the input channel and compares every
// result beat against an internal model of the recency-ordered directory.
// ----------------------------------------------------------------------------
module lru_writeback_object_cache_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOTS = 32;
    localparam logic FUNC_ACCESS = 1'b0;
    localparam logic FUNC_FLUSH  = 1'b1;

    typedef struct packed {
        logic        func;
        logic [15:0] object_id;
        logic        write;
    } t_req;

    typedef struct packed {
        logic [lwoc_pkg::KIND_W-1:0] kind;
        logic [lwoc_pkg::SLOT_W-1:0] slot;
        logic [lwoc_pkg::OBJ_W-1:0]  entry_object;
        logic                        hit;
        logic                        last;
    } t_beat;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_func;
    logic [15:0] in_object_id;
    logic in_write;
    logic in_stall;
    logic out_stall;
    logic out_valid;
    logic [lwoc_pkg::KIND_W-1:0] out_kind;
    logic [lwoc_pkg::SLOT_W-1:0] out_slot;
    logic [lwoc_pkg::OBJ_W-1:0] out_entry_object;
    logic out_hit;
    logic out_last;

    t_req  pending_reqs[$];
    t_beat expected_beats[$];
    int    errors = 0;
    bit    quiet = 0;
    int    in_gap = 0;
    int    out_gap = 0;

    // Model of the directory.
    logic [15:0] m_tag[NSLOTS];
    logic        m_dirty[NSLOTS];
    int          m_rank[NSLOTS];
    int          m_used;

    lru_writeback_object_cache i_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(out_stall),
        .i_func(in_func), .i_object_id(in_object_id), .i_write(in_write),
        .o_valid(out_valid), .i_stall(in_stall), .o_kind(out_kind),
        .o_slot(out_slot), .o_entry_object(out_entry_object), .o_hit(out_hit),
        .o_last(out_last)
    );

    always begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic int slot_of_rank(int r);
        for (int i = 0; i < m_used; i++)
            if (m_rank[i] == r) return i;
        return 0;
    endfunction

    function automatic void move_to_front(int s);
        int old;
        old = m_rank[s];
        for (int i = 0; i < m_used; i++)
            if (m_rank[i] < old) m_rank[i]++;
        m_rank[s] = 0;
    endfunction

    function automatic void push_beat(logic [lwoc_pkg::KIND_W-1:0] k, int s,
                                      logic [15:0] o, logic h);
        t_beat b;
        b.kind = k;
        b.slot = s[lwoc_pkg::SLOT_W-1:0];
        b.entry_object = o;
        b.hit = h;
        b.last = 1'b0;
        expected_beats.push_back(b);
    endfunction

    // Work out the result beats of one accepted request.
    function automatic void predict_cache(t_req q);
        int s;
        int t;
        bit found;
        found = 0;
        s = 0;
        if (q.func == FUNC_FLUSH) begin
            for (int r = 0; r < m_used; r++) begin
                t = slot_of_rank(r);
                if (m_dirty[t]) begin
                    push_beat(lwoc_pkg::KIND_WB, t, m_tag[t], 1'b0);
                    m_dirty[t] = 1'b0;
                end
            end
            push_beat(lwoc_pkg::KIND_DONE, 0, 16'd0, 1'b0);
        end else begin
            for (int i = 0; i < m_used && !found; i++)
                if (m_tag[i] == q.object_id) begin
                    s = i;
                    found = 1;
                end
            if (found) begin
                move_to_front(s);
                if (q.write) m_dirty[s] = 1'b1;
                push_beat(lwoc_pkg::KIND_DONE, s, q.object_id, 1'b1);
            end else begin
                if (m_used < NSLOTS) begin
                    s = m_used;
                    for (int i = 0; i < m_used; i++) m_rank[i]++;
                    m_rank[s] = 0;
                    m_used++;
                end else begin
                    s = slot_of_rank(m_used - 1);
                    if (m_dirty[s]) begin
                        for (int r = m_used - 1; r >= 0; r--) begin
                            t = slot_of_rank(r);
                            if (m_dirty[t]) begin
                                push_beat(lwoc_pkg::KIND_WB, t, m_tag[t], 1'b0);
                                m_dirty[t] = 1'b0;
                            end
                        end
                    end
                    move_to_front(s);
                end
                m_tag[s] = q.object_id;
                m_dirty[s] = q.write;
                push_beat(lwoc_pkg::KIND_FILL, s, q.object_id, 1'b0);
                push_beat(lwoc_pkg::KIND_DONE, s, q.object_id, 1'b0);
            end
        end
        expected_beats[$].last = 1'b1;
    endfunction

    // Driver: presents pending requests, with random idle bursts.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !out_stall) begin
                predict_cache('{in_func, in_object_id, in_write});
                void'(pending_reqs.pop_front());
            end
            if (!in_valid || !out_stall) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                    in_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    if (!quiet && $urandom_range(0, 9) == 0) begin
                        in_gap <= $urandom_range(1, 12);
                        in_valid <= 1'b0;
                    end else begin
                        in_valid <= 1'b1;
                        in_func <= pending_reqs[0].func;
                        in_object_id <= pending_reqs[0].object_id;
                        in_write <= pending_reqs[0].write;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result beat and stalls in random bursts.
    always @(posedge clk) begin
        t_beat exp_b;
        if (!rst_n) begin
            in_stall <= 1'b0;
        end else begin
            if (out_valid && !in_stall) begin
                if (expected_beats.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual %h", $time,
                             {out_kind, out_slot, out_entry_object, out_hit, out_last});
                    errors++;
                end else begin
                    exp_b = expected_beats.pop_front();
                    if (out_kind !== exp_b.kind) begin
                        $display("%0t: kind expected %0d actual %0d", $time, exp_b.kind,
                                 out_kind);
                        errors++;
                    end
                    if (out_slot !== exp_b.slot) begin
                        $display("%0t: slot expected %0d actual %0d", $time, exp_b.slot,
                                 out_slot);
                        errors++;
                    end
                    if (out_entry_object !== exp_b.entry_object) begin
                        $display("%0t: entry_object expected %h actual %h", $time,
                                 exp_b.entry_object, out_entry_object);
                        errors++;
                    end
                    if (out_hit !== exp_b.hit) begin
                        $display("%0t: hit expected %0d actual %0d", $time, exp_b.hit,
                                 out_hit);
                        errors++;
                    end
                    if (out_last !== exp_b.last) begin
                        $display("%0t: last expected %0d actual %0d", $time, exp_b.last,
                                 out_last);
                        errors++;
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                in_stall <= (out_gap > 1);
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                out_gap <= $urandom_range(1, 12);
                in_stall <= 1'b1;
            end else begin
                in_stall <= 1'b0;
            end
        end
    end

    function automatic void add_req(logic f, logic [15:0] o, logic w);
        t_req q;
        q.func = f;
        q.object_id = o;
        q.write = w;
        pending_reqs.push_back(q);
    endfunction

    initial begin
        logic [15:0] pool[48];
        int n;
        m_used = 0;
        for (int i = 0; i < NSLOTS; i++) begin
            m_tag[i] = '0;
            m_dirty[i] = 1'b0;
            m_rank[i] = 0;
        end
        in_valid = 1'b0;
        in_func = 1'b0;
        in_object_id = '0;
        in_write = 1'b0;
        in_stall = 1'b0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: flush of an empty cache, field extremes, hit, write hit,
        // flush of dirty entries, then filling and clean evictions.
        add_req(FUNC_FLUSH, 16'h0000, 1'b0);
        add_req(FUNC_ACCESS, 16'h0000, 1'b0);
        add_req(FUNC_ACCESS, 16'hFFFF, 1'b1);
        add_req(FUNC_ACCESS, 16'h0000, 1'b1);
        add_req(FUNC_ACCESS, 16'hFFFF, 1'b0);
        add_req(FUNC_FLUSH, 16'hFFFF, 1'b1);
        add_req(FUNC_FLUSH, 16'h5A5A, 1'b0);
        for (int i = 2; i < 34; i++)
            add_req(FUNC_ACCESS, 16'(16'h1000 + i), i[0]);
        add_req(FUNC_ACCESS, 16'h2000, 1'b0);
        add_req(FUNC_FLUSH, 16'h0, 1'b0);
        add_req(FUNC_ACCESS, 16'h2001, 1'b1);
        add_req(FUNC_ACCESS, 16'h2002, 1'b0);

        // Random: mostly a small working pool so hits, evictions and dirty
        // walks all happen, plus fully random object numbers.
        for (int i = 0; i < 48; i++) pool[i] = 16'($urandom);
        for (int i = 0; i < 500; i++) begin
            n = $urandom_range(0, 99);
            if (n < 5)
                add_req(FUNC_FLUSH, 16'($urandom), 1'($urandom_range(0, 1)));
            else if (n < 85)
                add_req(FUNC_ACCESS, pool[$urandom_range(0, 47)],
                        1'($urandom_range(0, 1)));
            else
                add_req(FUNC_ACCESS, 16'($urandom), 1'($urandom_range(0, 1)));
        end

        wait (pending_reqs.size() < 60);
        quiet = 1;
        wait (pending_reqs.size() == 0 && !in_valid);
        wait (expected_beats.size() == 0);
        repeat (100) @(posedge clk);
        if (errors == 0 && expected_beats.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule
